// File: sv/speaker_channel_birth_gate_macros.svh
// Assertion macros used by the birth gate checker.
`ifndef SPEAKER_CHANNEL_BIRTH_GATE_MACROS_SVH
`define SPEAKER_CHANNEL_BIRTH_GATE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SCBG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SCBG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/scbg_pkg.sv
// Types, constants and register map for the speaker channel birth gate.
`default_nettype none

package scbg_pkg;

    localparam int SPEAKERS   = 4;
    localparam int COUNT_BITS = 8;
    localparam int SPK_IDX_W  = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
    localparam int PROB_W     = 16;
    localparam int LEVEL_W    = 16;
    localparam int NEED_W     = 8;
    localparam int AGE_W      = 8;
    localparam int CMP_W      = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [PROB_W-1:0]     prob_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic [NEED_W-1:0]     need_t;
    typedef logic [AGE_W-1:0]      age_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SPK_IDX_W-1:0]  spk_idx_t;
    typedef logic [SPEAKERS-1:0]   spk_mask_t;

    localparam age_t   AGE_MAX   = {AGE_W{1'b1}};
    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam level_t SPEECH_LEVEL_RST       = 16'd9830;
    localparam level_t CLEAN_LEVEL_RST        = 16'd31130;
    localparam level_t QUIET_LEVEL_RST        = 16'd655;
    localparam level_t FADING_LEVEL_RST       = 16'd29491;
    localparam level_t FADING_QUIET_LEVEL_RST = 16'd4915;
    localparam need_t  CLEAN_NEEDED_RST       = 8'd4;
    localparam need_t  FADING_NEEDED_RST      = 8'd20;
    localparam age_t   EPISODE_GAP_RST        = 8'd25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEECH_LEVEL       = 3'd0,
        REG_CLEAN_LEVEL        = 3'd1,
        REG_QUIET_LEVEL        = 3'd2,
        REG_FADING_LEVEL       = 3'd3,
        REG_FADING_QUIET_LEVEL = 3'd4,
        REG_CLEAN_NEEDED       = 3'd5,
        REG_FADING_NEEDED      = 3'd6,
        REG_EPISODE_GAP        = 3'd7
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/speaker_channel_birth_gate.sv
// Speaker channel birth gate: speaker establishment tracking and frame relabelling.
// A frame of four speaker probabilities is accepted in any cycle the input is not
// stalled. It is evaluated combinationally from the input register and written into
// the result register, which drives the outputs until the downstream side takes it.
// A new frame can follow every cycle while the output is not stalled, so the sustained
// rate is one frame per clock. The rate is set by the per-speaker counter and age
// state, which one frame reads and rewrites as it leaves the input register, before
// the next frame uses it. The result register lets the next frame enter while
// a finished result waits for the downstream side. Configuration writes are always
// ready and take effect on the following frame.
`default_nettype none

module speaker_channel_birth_gate (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire scbg_pkg::prob_t              prob_0,
    input  wire scbg_pkg::prob_t              prob_1,
    input  wire scbg_pkg::prob_t              prob_2,
    input  wire scbg_pkg::prob_t              prob_3,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output scbg_pkg::prob_t                   out_prob_0,
    output scbg_pkg::prob_t                   out_prob_1,
    output scbg_pkg::prob_t                   out_prob_2,
    output scbg_pkg::prob_t                   out_prob_3,
    output logic                              newly_established,
    output scbg_pkg::spk_mask_t               established_mask,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [scbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scbg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import scbg_pkg::*;

    // configuration registers
    level_t speech_level_reg;
    level_t clean_level_reg;
    level_t quiet_level_reg;
    level_t fading_level_reg;
    level_t fading_quiet_level_reg;
    need_t  clean_needed_reg;
    need_t  fading_needed_reg;
    age_t   episode_gap_reg;

    // pipeline
    logic   in_valid_reg;
    prob_t  prob_reg [SPEAKERS];
    logic   out_valid_reg;
    prob_t  out_prob_reg [SPEAKERS];
    logic   born_reg;
    logic   advance;
    logic   fire;

    // per-speaker state
    spk_mask_t flag_reg;
    count_t    clean_count_reg  [SPEAKERS];
    count_t    fading_count_reg [SPEAKERS];
    age_t      age_reg          [SPEAKERS];

    spk_mask_t flag_next;
    count_t    clean_count_next  [SPEAKERS];
    count_t    fading_count_next [SPEAKERS];
    age_t      age_next          [SPEAKERS];
    prob_t     relabel_next      [SPEAKERS];
    logic      born_next;

    prob_t     prob_in [SPEAKERS];

    assign prob_in[0] = prob_0;
    assign prob_in[1] = prob_1;
    assign prob_in[2] = prob_2;
    assign prob_in[3] = prob_3;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    function automatic count_t count_inc(input count_t c);
        return (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

    function automatic age_t age_inc(input age_t a);
        return (a == AGE_MAX) ? a : a + age_t'(1);
    endfunction

    // frame evaluation: winner, counter update, birth, relabel
    always_comb
    begin
        spk_idx_t win;
        prob_t    pwin;
        logic     qualify;
        prob_t    est_max;
        logic     gap_clear;
        count_t   clean_base;
        count_t   fading_base;
        count_t   clean_upd;
        count_t   fading_upd;
        logic     have_target;
        spk_idx_t target;
        prob_t    fold_max;

        win = '0;
        pwin = prob_reg[0];
        for (int s = 1; s < SPEAKERS; s++)
        begin
            if (prob_reg[s] > pwin)
            begin
                win  = spk_idx_t'(s);
                pwin = prob_reg[s];
            end
        end

        qualify = (pwin >= speech_level_reg) && !flag_reg[win];

        est_max = '0;
        for (int s = 0; s < SPEAKERS; s++)
        begin
            if (flag_reg[s] && prob_reg[s] > est_max)
                est_max = prob_reg[s];
        end

        gap_clear   = (age_reg[win] == AGE_MAX) || (age_reg[win] > episode_gap_reg);
        clean_base  = gap_clear ? '0 : clean_count_reg[win];
        fading_base = gap_clear ? '0 : fading_count_reg[win];
        clean_upd   = (pwin >= clean_level_reg && est_max <= quiet_level_reg)
                      ? count_inc(clean_base) : clean_base;
        fading_upd  = (pwin >= fading_level_reg && est_max <= fading_quiet_level_reg)
                      ? count_inc(fading_base) : fading_base;
        born_next   = qualify && ((CMP_W'(clean_upd) >= CMP_W'(clean_needed_reg)) ||
                                  (CMP_W'(fading_upd) >= CMP_W'(fading_needed_reg)));

        flag_next = flag_reg;
        for (int s = 0; s < SPEAKERS; s++)
        begin
            clean_count_next[s]  = clean_count_reg[s];
            fading_count_next[s] = fading_count_reg[s];
            age_next[s]          = age_inc(age_reg[s]);
            if (qualify && win == spk_idx_t'(s))
            begin
                clean_count_next[s]  = clean_upd;
                fading_count_next[s] = fading_upd;
                age_next[s]          = age_t'(1);
                flag_next[s]         = flag_reg[s] | born_next;
            end
        end

        // fold unestablished probability into the strongest established speaker
        have_target = 1'b0;
        target      = '0;
        fold_max    = '0;
        for (int s = 0; s < SPEAKERS; s++)
        begin
            if (flag_next[s] && (!have_target || prob_reg[s] > prob_reg[target]))
            begin
                have_target = 1'b1;
                target      = spk_idx_t'(s);
            end
            if (!flag_next[s] && prob_reg[s] > fold_max)
                fold_max = prob_reg[s];
        end

        for (int s = 0; s < SPEAKERS; s++)
        begin
            relabel_next[s] = prob_reg[s];
            if (have_target)
            begin
                if (!flag_next[s])
                    relabel_next[s] = '0;
                else if (target == spk_idx_t'(s) && fold_max > prob_reg[s])
                    relabel_next[s] = fold_max;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speech_level_reg       <= SPEECH_LEVEL_RST;
            clean_level_reg        <= CLEAN_LEVEL_RST;
            quiet_level_reg        <= QUIET_LEVEL_RST;
            fading_level_reg       <= FADING_LEVEL_RST;
            fading_quiet_level_reg <= FADING_QUIET_LEVEL_RST;
            clean_needed_reg       <= CLEAN_NEEDED_RST;
            fading_needed_reg      <= FADING_NEEDED_RST;
            episode_gap_reg        <= EPISODE_GAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SPEECH_LEVEL:       speech_level_reg       <= level_t'(cfg_data);
                REG_CLEAN_LEVEL:        clean_level_reg        <= level_t'(cfg_data);
                REG_QUIET_LEVEL:        quiet_level_reg        <= level_t'(cfg_data);
                REG_FADING_LEVEL:       fading_level_reg       <= level_t'(cfg_data);
                REG_FADING_QUIET_LEVEL: fading_quiet_level_reg <= level_t'(cfg_data);
                REG_CLEAN_NEEDED:       clean_needed_reg       <= cfg_data[NEED_W-1:0];
                REG_FADING_NEEDED:      fading_needed_reg      <= cfg_data[NEED_W-1:0];
                REG_EPISODE_GAP:        episode_gap_reg        <= cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control and speaker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
            for (int s = 0; s < SPEAKERS; s++)
            begin
                clean_count_reg[s]  <= '0;
                fading_count_reg[s] <= '0;
                age_reg[s]          <= AGE_MAX;
            end
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            // advance state once per frame leaving the input register
            if (fire)
            begin
                flag_reg <= flag_next;
                for (int s = 0; s < SPEAKERS; s++)
                begin
                    clean_count_reg[s]  <= clean_count_next[s];
                    fading_count_reg[s] <= fading_count_next[s];
                    age_reg[s]          <= age_next[s];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            for (int s = 0; s < SPEAKERS; s++)
                prob_reg[s] <= prob_in[s];
        end
        if (fire)
        begin
            for (int s = 0; s < SPEAKERS; s++)
                out_prob_reg[s] <= relabel_next[s];
            born_reg <= born_next;
        end
    end

    // the mask follows the state, which only moves when a new result is loaded
    assign out_valid         = out_valid_reg;
    assign out_prob_0        = out_prob_reg[0];
    assign out_prob_1        = out_prob_reg[1];
    assign out_prob_2        = out_prob_reg[2];
    assign out_prob_3        = out_prob_reg[3];
    assign newly_established = born_reg;
    assign established_mask  = flag_reg;

endmodule

`default_nettype wire

// File: sv/scbg_checker.sv
// Port-level checker for the speaker channel birth gate, bound to the top level.
`default_nettype none
`include "speaker_channel_birth_gate_macros.svh"

module scbg_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire scbg_pkg::prob_t              out_prob_0,
    input wire scbg_pkg::prob_t              out_prob_3,
    input wire logic                         newly_established,
    input wire scbg_pkg::spk_mask_t          established_mask
);
    import scbg_pkg::*;

    // a stalled result transaction holds its payload
    `SCBG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_prob_0) && $stable(out_prob_3) && $stable(newly_established) && $stable(established_mask), "stalled result changed")

    // a birth always leaves at least one established speaker
    `SCBG_ASSERT(a_birth_mask, out_valid && newly_established |-> established_mask != '0, "birth reported with empty mask")

    // once any speaker is established, unestablished speakers read zero
    `SCBG_ASSERT(a_fold_zero_0, out_valid && established_mask != '0 && !established_mask[0] |-> out_prob_0 == '0, "speaker 0 not folded")

    `SCBG_ASSERT(a_fold_zero_3, out_valid && established_mask != '0 && !established_mask[3] |-> out_prob_3 == '0, "speaker 3 not folded")

    // a clock edge seen in reset leaves the pipeline empty for the next edge
    `SCBG_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid && !in_stall, "pipeline busy after reset")

endmodule

bind speaker_channel_birth_gate scbg_checker u_scbg_checker (.*);

`default_nettype wire
